// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the CAN frame dispatch filter.
// Needs signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cfd_pkg.sv =====
// Shared types, codes and the SDO payload decoder for the CAN frame dispatch filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam int ID_W      = 29;
    localparam int TAG_W     = 8;
    localparam int NODE_W    = 7;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_OUT_W = 4;
    localparam int KIND_W    = 3;

    // request codes
    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_ATTACH = 2'd1;
    localparam logic [1:0] REQ_DETACH = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RAW      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PDO      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SDO_REQ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SDO_RESP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOMATCH  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ATTACHED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_DETACHED = 3'd7;

    // CANopen identifier ranges
    localparam logic [ID_W-1:0] PDO_ID_LO    = 29'h17F;
    localparam logic [ID_W-1:0] SDO_RESP_BASE = 29'h580;
    localparam logic [ID_W-1:0] SDO_REQ_BASE  = 29'h600;

    // SDO command bytes without a data count
    localparam logic [7:0] SDO_CMD_UPLOAD_REQ = 8'h40;
    localparam logic [7:0] SDO_CMD_DNLOAD_RSP = 8'h60;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   mask;
        logic              ext;
        logic              canopen;
        logic [NODE_W-1:0] node;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } match_t;

    typedef struct packed {
        logic [15:0] index;
        logic [7:0]  subindex;
        logic [3:0]  command;
        logic [2:0]  length;
        logic [31:0] data;
    } sdo_t;

    function automatic sdo_t sdo_decode(input logic [PAYLOAD_W-1:0] pl);
        sdo_t       r;
        logic [7:0] b0;
        logic [2:0] len;
        int         x;
        b0 = pl[7:0];
        if (b0 == SDO_CMD_UPLOAD_REQ || b0 == SDO_CMD_DNLOAD_RSP)
        begin
            len = 3'd0;
        end
        else
        begin
            len = 3'd4 - {1'b0, b0[3:2]};
        end
        r.index    = pl[23:8];
        r.subindex = pl[31:24];
        r.command  = b0[7:4];
        r.length   = len;
        for (x = 0; x < 4; x++)
        begin
            r.data[8*x +: 8] = (3'(x) < len) ? pl[32 + 8*x +: 8] : 8'h00;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/can_frame_dispatch_filter_top.sv =====
// CAN subscriber table with acceptance filtering and CANopen SDO decode.
//
// Input channel s_*: one request per handshake; s_tuser carries the request
// type (frame, attach, detach). Output channel m_*: one result per handshake,
// m_tuser carries the result kind, m_tlast marks the final result of a request.
// A request walks the table one slot a cycle while the walk is not paused,
// through a single compare unit, reading the entry RAM one slot ahead. A frame
// or detach walks every slot (a frame stops after MAX_RESULTS results);
// s_tready returns high as the final result appears on m_*. An attach stops at
// the first free slot. An unknown request type is dropped without a result.
// s_tready is high only between requests. Results pass through a one-deep
// holding stage and an output register, so the walk continues while one result
// waits; a second match while both are full pauses the walk until m_tready.
// Reset clears all slot valid bits and the handshake state; the entry RAM is
// not cleared, as the contents of invalid slots are never used.
// Depends on cfd_pkg, cfd_ram, cfd_match and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module can_frame_dispatch_filter_top
    import cfd_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // can_id[28:0], is_extended[29], payload[93:30], filter_mask[122:94],
    // observer_tag[130:123], canopen_mode[131], node_id[138:132], zero pad
    input  wire logic [143:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot[3:0], tag_out[11:4], sdo_index[27:12], sdo_subindex[35:28],
    // sdo_cmd[39:36], sdo_length[42:40], sdo_data[74:43], zero pad
    output logic [79:0]       m_tdata,
    // kind[2:0]
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next, idx_inc;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;

    // latched request
    logic [1:0]           req_reg, req_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic                 ext_reg, ext_next;
    logic [PAYLOAD_W-1:0] pl_reg, pl_next;
    logic [ID_W-1:0]      mask_reg, mask_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic                 co_reg, co_next;
    logic [NODE_W-1:0]    node_reg, node_next;

    // holding stage
    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_OUT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]      pend_tag_reg, pend_tag_next;
    logic [KIND_W-1:0]     pend_kind_reg, pend_kind_next;
    sdo_t                  pend_sdo_reg, pend_sdo_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;
    sdo_t                  out_sdo_reg, out_sdo_next;
    logic                  out_last_reg, out_last_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    match_t            mres;

    logic out_free;
    logic is_last;
    logic gen;
    logic stall;

    assign ram_wdata = '{tag: tag_reg, id: id_reg, mask: mask_reg, ext: ext_reg,
                         canopen: co_reg, node: node_reg};

    cfd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS),
        .AW    (SLOT_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfd_match u_match (
        .req_type    (req_reg),
        .ent         (ram_rdata),
        .ent_valid   (valid_reg[idx_reg]),
        .can_id      (id_reg),
        .filter_mask (mask_reg),
        .tag         (tag_reg),
        .res         (mres)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign is_last  = (idx_reg == LAST_SLOT);
    assign idx_inc  = is_last ? '0 : idx_reg + SLOT_W'(1);
    assign gen      = mres.hit && (n_reg < CNT_W'(MAX_RESULTS));
    assign stall    = gen && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        valid_next      = valid_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        ext_next        = ext_reg;
        pl_next         = pl_reg;
        mask_next       = mask_reg;
        tag_next        = tag_reg;
        co_next         = co_reg;
        node_next       = node_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        pend_kind_next  = pend_kind_reg;
        pend_sdo_next   = pend_sdo_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_kind_next   = out_kind_reg;
        out_sdo_next    = out_sdo_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = s_tuser;
                    id_next         = s_tdata[28:0];
                    ext_next        = s_tdata[29];
                    pl_next         = s_tdata[93:30];
                    mask_next       = s_tdata[122:94];
                    tag_next        = s_tdata[130:123];
                    co_next         = s_tdata[131];
                    node_next       = s_tdata[138:132];
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    if (s_tuser == REQ_FRAME || s_tuser == REQ_ATTACH
                        || s_tuser == REQ_DETACH)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                ram_raddr = idx_reg;
                if (req_reg == REQ_FRAME && n_reg == CNT_W'(MAX_RESULTS))
                begin
                    state_next = ST_FLUSH;
                end
                else if (!stall)
                begin
                    if (gen)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_slot_next  = pend_slot_reg;
                            out_tag_next   = pend_tag_reg;
                            out_kind_next  = pend_kind_reg;
                            out_sdo_next   = pend_sdo_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_OUT_W'(idx_reg);
                        pend_tag_next   = (req_reg == REQ_FRAME) ? ram_rdata.tag : tag_reg;
                        pend_kind_next  = mres.kind;
                        pend_sdo_next   = (mres.kind == KIND_SDO_REQ
                                           || mres.kind == KIND_SDO_RESP)
                                          ? sdo_decode(pl_reg) : '0;
                        n_next          = n_reg + CNT_W'(1);
                    end
                    if (mres.hit && req_reg == REQ_DETACH)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (mres.hit && req_reg == REQ_ATTACH)
                    begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        state_next          = ST_FLUSH;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_slot_next = pend_slot_reg;
                        out_tag_next  = pend_tag_reg;
                        out_kind_next = pend_kind_reg;
                        out_sdo_next  = pend_sdo_reg;
                    end
                    else
                    begin
                        out_slot_next = '0;
                        out_tag_next  = (req_reg == REQ_FRAME) ? '0 : tag_reg;
                        out_kind_next = (req_reg == REQ_ATTACH) ? KIND_FULL : KIND_NOMATCH;
                        out_sdo_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            valid_reg      <= '0;
            req_reg        <= REQ_FRAME;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            valid_reg      <= valid_next;
            req_reg        <= req_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        ext_reg       <= ext_next;
        pl_reg        <= pl_next;
        mask_reg      <= mask_next;
        tag_reg       <= tag_next;
        co_reg        <= co_next;
        node_reg      <= node_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        pend_kind_reg <= pend_kind_next;
        pend_sdo_reg  <= pend_sdo_next;
        out_slot_reg  <= out_slot_next;
        out_tag_reg   <= out_tag_next;
        out_kind_reg  <= out_kind_next;
        out_sdo_reg   <= out_sdo_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_sdo_reg.data, out_sdo_reg.length, out_sdo_reg.command,
                       out_sdo_reg.subindex, out_sdo_reg.index, out_tag_reg, out_slot_reg};

    `CFD_ASSERT(a_idle_no_pending, s_tready |-> !pend_valid_reg,
                "holding stage occupied while a new request may be taken")
    `CFD_ASSERT(a_result_count, n_reg <= CNT_W'(MAX_RESULTS),
                "result count past its limit")
    `CFD_ASSERT(a_attach_free_slot, ram_we |-> !valid_reg[idx_reg] && req_reg == REQ_ATTACH,
                "entry written into an occupied slot")
    `CFD_ASSERT(a_flush_final, state_reg == ST_FLUSH && out_free |=> m_tvalid && m_tlast,
                "request finished without a final result")
    `CFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid && valid_reg == '0,
                       "output or table not cleared in reset")

endmodule

`default_nettype wire

// ===== hdl/cfd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/cfd_match.sv =====
// Shared compare unit: tests one table slot against the current request.
// Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_match
    import cfd_pkg::*;
(
    input  wire logic [1:0]       req_type,
    input  wire entry_t           ent,
    input  wire logic             ent_valid,
    input  wire logic [ID_W-1:0]  can_id,
    input  wire logic [ID_W-1:0]  filter_mask,
    input  wire logic [TAG_W-1:0] tag,
    output match_t                res
);

    logic [ID_W-1:0] node_ext;

    assign node_ext = ID_W'(ent.node);

    always_comb
    begin
        res = '0;
        case (req_type)
            REQ_FRAME:
            begin
                if (ent_valid)
                begin
                    if (ent.canopen)
                    begin
                        if (can_id > PDO_ID_LO && can_id < SDO_RESP_BASE)
                        begin
                            res.hit  = 1'b1;
                            res.kind = KIND_PDO;
                        end
                        else if (can_id == SDO_REQ_BASE + node_ext)
                        begin
                            res.hit  = 1'b1;
                            res.kind = KIND_SDO_REQ;
                        end
                        else if (can_id == SDO_RESP_BASE + node_ext)
                        begin
                            res.hit  = 1'b1;
                            res.kind = KIND_SDO_RESP;
                        end
                    end
                    else if ((can_id & ent.mask) == (ent.id & ent.mask))
                    begin
                        res.hit  = 1'b1;
                        res.kind = KIND_RAW;
                    end
                end
            end
            REQ_ATTACH:
            begin
                res.hit  = !ent_valid;
                res.kind = KIND_ATTACHED;
            end
            REQ_DETACH:
            begin
                res.hit  = ent_valid && ent.tag == tag && ent.id == can_id
                           && ent.mask == filter_mask;
                res.kind = KIND_DETACHED;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
